@@ hdl/sieu_pkg.sv @@
// Package with the opcode, condition and flag constants and the channel payload types.
package sieu_pkg;

    localparam int NUM_REGS   = 16;
    localparam int DATA_WIDTH = 64;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int FLAG_W     = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam int F_EQ   = 0;
    localparam int F_GT   = 1;
    localparam int F_LT   = 2;
    localparam int F_ZERO = 3;
    localparam int F_OVF  = 5;
    localparam int F_IE   = 6;
    localparam int F_PE   = 7;
    localparam int F_USER = 8;
    localparam int F_SGT  = 9;
    localparam int F_SLT  = 10;

    localparam logic [4:0] OP_ADD = 5'd0, OP_SUB = 5'd1, OP_INC = 5'd2, OP_DEC = 5'd3,
        OP_CMP = 5'd4, OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_NOT = 5'd8,
        OP_SHL = 5'd9, OP_SHR = 5'd10, OP_ROL = 5'd11, OP_ROR = 5'd12, OP_LDI = 5'd13,
        OP_CUT = 5'd14, OP_ICUT = 5'd15, OP_JC = 5'd16, OP_CALL = 5'd17, OP_RET = 5'd18,
        OP_LOOP = 5'd19, OP_SYSCALL = 5'd20, OP_SYSRET = 5'd21, OP_EI = 5'd22,
        OP_DI = 5'd23, OP_EP = 5'd24, OP_DP = 5'd25;

    localparam logic [3:0] C_ALWAYS = 4'd0, C_NEQ = 4'd1, C_NGT = 4'd2, C_NLT = 4'd3,
        C_EQ = 4'd4, C_GT = 4'd5, C_LT = 4'd6, C_NSGT = 4'd7, C_NSLT = 4'd8,
        C_SGT = 4'd9, C_SLT = 4'd10, C_OVF = 4'd11, C_ZERO = 4'd12;

    typedef struct packed {
        logic [4:0]  op;
        logic [3:0]  src_a;
        logic [3:0]  src_b;
        logic [3:0]  dst;
        logic [63:0] imm;
        logic [1:0]  imm_size;
        logic [3:0]  cond;
        logic [3:0]  width_code;
    } sieu_in_t;

    typedef struct packed {
        logic [63:0] next_ip;
        logic        redirect;
        logic        perm_fault;
        logic [10:0] flags_out;
        logic        wb_enable;
        logic [3:0]  wb_index;
        logic [63:0] wb_value;
    } sieu_out_t;

    typedef enum logic [2:0] {
        CL_ALU, CL_SHIFT, CL_LDI, CL_BRANCH, CL_SYS, CL_NONE
    } op_class_t;

    // Classified instruction passed from the front end to the back end.
    typedef struct packed {
        sieu_in_t             item;
        op_class_t            cls;
        logic                 priv;
        logic [REG_IDX_W-1:0] a_ix;
        logic [REG_IDX_W-1:0] b_ix;
        logic [REG_IDX_W-1:0] d_ix;
        logic [3:0]           len;
    } dec_t;

endpackage

@@ hdl/small_isa_execute_unit_top.sv @@
// Channel   | Direction | Handshake           | Payload
// s_        | in        | s_valid / s_ready   | s_data (sieu_in_t)
// m_        | out       | m_valid / m_ready   | m_data (sieu_out_t)
// cfg_      | in        | cfg_we              | cfg_wdata (syscall entry)
// One instruction per cycle unless m_ready stalls; a result appears in the cycle after it leaves the queue.
// The execute stage updates registers, flags and pointer in the same cycle, which sets the rate.
// A two-entry queue between decode and execute lets either side stall on its own.
// Reset is synchronous on aresetn low and clears all registers, flags and the pointer.
module small_isa_execute_unit_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [63:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  sieu_pkg::sieu_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sieu_pkg::sieu_out_t m_data
);
    import sieu_pkg::*;

    dec_t q_data;
    logic q_valid, q_ready;

    sieu_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    sieu_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

@@ hdl/sieu_front.sv @@
// Front end: accepts instructions, classifies them and feeds a short queue.
module sieu_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sieu_pkg::sieu_in_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output sieu_pkg::dec_t     q_data
);
    import sieu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    dec_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    dec_t             dec;
    logic             push, pop;

    always_comb begin
        dec = '0;
        dec.item = s_data;
        dec.a_ix = s_data.src_a[REG_IDX_W-1:0];
        dec.b_ix = s_data.src_b[REG_IDX_W-1:0];
        dec.d_ix = s_data.dst[REG_IDX_W-1:0];
        dec.priv = 1'b0;
        dec.len  = 4'd1;
        unique case (s_data.op)
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
                dec.cls = CL_ALU;
                dec.len = 4'd3;
            end
            OP_INC, OP_DEC, OP_CMP, OP_NOT, OP_CUT, OP_ICUT: begin
                dec.cls = CL_ALU;
                dec.len = 4'd2;
            end
            OP_SHL, OP_SHR, OP_ROL, OP_ROR: begin
                dec.cls = CL_SHIFT;
                dec.len = 4'd2;
            end
            OP_LDI: begin
                dec.cls = CL_LDI;
                case (s_data.imm_size)
                    2'd0: dec.len = 4'd3;
                    2'd1: dec.len = 4'd4;
                    2'd2: dec.len = 4'd6;
                    default: dec.len = 4'd10;
                endcase
            end
            OP_JC, OP_CALL: begin
                dec.cls = CL_BRANCH;
                case (s_data.imm_size)
                    2'd0: dec.len = 4'd4;
                    2'd1: dec.len = 4'd6;
                    2'd2: dec.len = 4'd10;
                    default: dec.len = 4'd5;
                endcase
            end
            OP_RET: dec.cls = CL_BRANCH;
            OP_LOOP: begin
                dec.cls = CL_BRANCH;
                dec.len = 4'd6;
            end
            OP_SYSCALL: dec.cls = CL_SYS;
            OP_SYSRET, OP_EI, OP_DI, OP_EP, OP_DP: begin
                dec.cls  = CL_SYS;
                dec.priv = 1'b1;
            end
            default: dec.cls = CL_NONE;
        endcase
    end

    assign s_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH)) || q_ready;
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == (PTR_W+1)'(QUEUE_DEPTH) && !q_ready |-> !s_ready)
        else $error("queue accepted a transaction while full");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");
    a_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> !q_valid)
        else $error("queue offered data while empty");

endmodule

@@ hdl/sieu_back.sv @@
// Back end: executes classified instructions against the architectural state.
module sieu_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [63:0]         cfg_wdata,
    input  logic                q_valid,
    output logic                q_ready,
    input  sieu_pkg::dec_t      q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sieu_pkg::sieu_out_t m_data
);
    import sieu_pkg::*;

    logic [63:0]     regs_reg [NUM_REGS];
    logic [10:0]     flags_reg, flags_next;
    logic [63:0]     ip_reg, ip_next, entry_reg;
    logic            out_valid_reg;
    sieu_out_t       out_reg, res;
    logic [63:0]     ra, rb, rd, r0, v, off, tgt, ip_len;
    logic [5:0]      sh, rol_n;
    logic            take, fire, user, cnd;
    sieu_in_t        it;

    assign it   = q_data.item;
    assign ra   = regs_reg[q_data.a_ix];
    assign rb   = regs_reg[q_data.b_ix];
    assign rd   = regs_reg[q_data.d_ix];
    assign r0   = regs_reg[0];
    assign user = flags_reg[F_USER];
    assign ip_len = ip_reg + {60'd0, q_data.len};
    assign sh   = ra[5:0];
    assign rol_n = (it.op == OP_ROR) ? 6'd0 - sh : sh;

    assign q_ready = !out_valid_reg || m_ready;
    assign fire    = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (it.cond)
            C_ALWAYS: cnd = 1'b1;
            C_NEQ:    cnd = !flags_reg[F_EQ];
            C_NGT:    cnd = !flags_reg[F_GT];
            C_NLT:    cnd = !flags_reg[F_LT];
            C_EQ:     cnd = flags_reg[F_EQ];
            C_GT:     cnd = flags_reg[F_GT];
            C_LT:     cnd = flags_reg[F_LT];
            C_NSGT:   cnd = !flags_reg[F_SGT];
            C_NSLT:   cnd = !flags_reg[F_SLT];
            C_SGT:    cnd = flags_reg[F_SGT];
            C_SLT:    cnd = flags_reg[F_SLT];
            C_OVF:    cnd = flags_reg[F_OVF];
            C_ZERO:   cnd = flags_reg[F_ZERO];
            default:  cnd = 1'b0;
        endcase
    end

    always_comb begin
        case (it.imm_size)
            2'd0:    tgt = {48'd0, it.imm[15:0]};
            2'd1:    tgt = {32'd0, it.imm[31:0]};
            default: tgt = it.imm;
        endcase
    end

    assign off = {{32{it.imm[31]}}, it.imm[31:0]};

    always_comb begin
        res = '0;
        flags_next = flags_reg;
        v = '0;
        take = 1'b0;
        res.next_ip = ip_len;
        unique case (it.op)
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_DEC: begin
                case (it.op)
                    OP_ADD:  v = ra + rb;
                    OP_SUB:  v = ra - rb;
                    OP_AND:  v = ra & rb;
                    OP_OR:   v = ra | rb;
                    OP_XOR:  v = ra ^ rb;
                    OP_NOT:  v = ~ra;
                    default: v = rd - 64'd1;
                endcase
                flags_next[F_ZERO] = (v == '0);
                take = 1'b1;
            end
            OP_INC: begin
                v = rd + 64'd1;
                flags_next[F_OVF] = (v == '0);
                take = 1'b1;
            end
            OP_CMP: begin
                flags_next[F_EQ]  = (ra == rb);
                flags_next[F_GT]  = (ra > rb);
                flags_next[F_LT]  = (ra < rb);
                flags_next[F_SGT] = ($signed(ra) > $signed(rb));
                flags_next[F_SLT] = ($signed(ra) < $signed(rb));
            end
            OP_SHL: begin
                v = (ra[63:6] != '0) ? '0 : rd << sh;
                take = 1'b1;
            end
            OP_SHR: begin
                v = (ra[63:6] != '0) ? '0 : rd >> sh;
                take = 1'b1;
            end
            OP_ROL, OP_ROR: begin
                v = (rd << rol_n) | ((rol_n == 6'd0) ? '0 : rd >> (7'd64 - {1'b0, rol_n}));
                take = 1'b1;
            end
            OP_LDI: begin
                case (it.imm_size)
                    2'd0:    v = {56'd0, it.imm[7:0]};
                    2'd1:    v = {48'd0, it.imm[15:0]};
                    2'd2:    v = {32'd0, it.imm[31:0]};
                    default: v = it.imm;
                endcase
                take = 1'b1;
            end
            OP_CUT, OP_ICUT: begin
                take = 1'b1;
                case (it.width_code)
                    4'd1: v = {{56{rd[7] & it.op[0]}}, rd[7:0]};
                    4'd2: v = {{48{rd[15] & it.op[0]}}, rd[15:0]};
                    4'd4: v = {{32{rd[31] & it.op[0]}}, rd[31:0]};
                    default: take = 1'b0;
                endcase
            end
            OP_JC, OP_CALL: begin
                if (cnd) begin
                    res.next_ip  = tgt;
                    res.redirect = 1'b1;
                    if (it.op == OP_CALL) begin
                        v = ip_len;
                        take = 1'b1;
                    end
                end
            end
            OP_RET: begin
                res.next_ip  = r0;
                res.redirect = 1'b1;
            end
            OP_LOOP: begin
                if (rd != '0) begin
                    v = rd - 64'd1;
                    take = 1'b1;
                    res.next_ip  = ip_reg + off;
                    res.redirect = 1'b1;
                end
            end
            OP_SYSCALL: begin
                v = ip_reg;
                take = 1'b1;
                flags_next[F_USER] = 1'b1;
                res.next_ip  = entry_reg;
                res.redirect = 1'b1;
            end
            OP_SYSRET: begin
                flags_next[F_USER] = 1'b0;
                res.next_ip  = r0 + 64'd1;
                res.redirect = 1'b1;
            end
            OP_EI, OP_DI: flags_next[F_IE] = (it.op == OP_EI);
            OP_EP, OP_DP: flags_next[F_PE] = (it.op == OP_EP);
            default: ;
        endcase
        // Calls and syscalls link through register zero.
        res.perm_fault = q_data.priv && user;
        res.flags_out  = flags_next;
        res.wb_enable  = take;
        if (take) begin
            res.wb_index = (it.op == OP_CALL || it.op == OP_SYSCALL) ? 4'd0
                         : 4'(q_data.d_ix);
            res.wb_value = v;
        end
    end

    assign ip_next = res.next_ip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
            flags_reg     <= '0;
            ip_reg        <= '0;
            entry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                entry_reg <= cfg_wdata;
            end
            if (fire) begin
                flags_reg <= flags_next;
                ip_reg    <= ip_next;
                if (res.wb_enable) begin
                    regs_reg[res.wb_index[REG_IDX_W-1:0]] <= res.wb_value;
                end
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    a_ip_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> ip_reg == out_reg.next_ip)
        else $error("pointer and reported next_ip disagree");
    a_flags_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> flags_reg == out_reg.flags_out)
        else $error("flag word and reported flags disagree");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(ip_reg) && $stable(flags_reg))
        else $error("state changed without a transaction");

endmodule
